// ===== src/sts_pkg.sv =====
package sts_pkg;

  localparam int TIME_W  = 16;
  localparam int PASS_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int PCNT_W  = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // one slot as held in the table ram
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] service;
    logic [TIME_W-1:0] stride;
    logic [TIME_W-1:0] run;
    logic [PASS_W-1:0] pass;
  } slot_entry_t;

  // sequencer to selector
  typedef struct packed {
    logic              clear;
    logic              check;
    logic [TIME_W-1:0] now;
  } sel_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_RESULT = 5'b10000
  } seq_state_t;

endpackage

// ===== src/sts_req_if.sv =====
interface sts_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [sts_pkg::SLOT_W-1:0]     slot;
  logic [sts_pkg::TIME_W-1:0]     arrival_time;
  logic [sts_pkg::TIME_W-1:0]     service_time;
  logic [sts_pkg::TIME_W-1:0]     stride_value;

  modport source (
    output valid, req_type, slot, arrival_time, service_time, stride_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, slot, arrival_time, service_time, stride_value,
    output ready
  );
endinterface

// ===== src/sts_res_if.sv =====
interface sts_res_if;
  logic                           valid;
  logic                           ready;
  logic                           run_valid;
  logic [sts_pkg::SLOT_W-1:0]     run_slot;
  logic [sts_pkg::TIME_W-1:0]     tick_time;
  logic                           all_done;

  modport source (
    output valid, run_valid, run_slot, tick_time, all_done,
    input  ready
  );
  modport sink (
    input  valid, run_valid, run_slot, tick_time, all_done,
    output ready
  );
endinterface

// ===== src/sts_ram.sv =====
module sts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sts_select.sv =====
module sts_select #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sts_pkg::sel_ctl_t                   ctl,
  input  logic [$clog2(MAX_SLOTS)-1:0]        chk_idx,
  input  sts_pkg::slot_entry_t                entry,
  output logic                                found,
  output logic [$clog2(MAX_SLOTS)-1:0]        best_idx,
  output sts_pkg::slot_entry_t                best_entry,
  output logic [$clog2(MAX_SLOTS+1)-1:0]      unfin
);

  localparam int CNTW = $clog2(MAX_SLOTS+1);

  logic unfinished;
  logic eligible;
  logic better;

  // the shared compare unit: one slot per cycle while check is set
  always_comb begin
    unfinished = entry.run < entry.service;
    eligible   = unfinished && (entry.arrival <= ctl.now);
    better     = !found || (entry.pass < best_entry.pass);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      unfin <= '0;
    end else if (ctl.clear) begin
      found <= 1'b0;
      unfin <= '0;
    end else if (ctl.check) begin
      if (eligible && better) begin
        found <= 1'b1;
      end
      unfin <= unfin + CNTW'(unfinished);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.check && eligible && better) begin
      best_idx   <= chk_idx;
      best_entry <= entry;
    end
  end

  // a granted slot was counted as unfinished
  a_grant_unfinished: assert property (@(posedge clk) disable iff (rst)
    found |-> (unfin != '0))
    else $error("grant held with no unfinished slot");

  // a new tick starts from an empty selection
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (!found && unfin == '0))
    else $error("selection not cleared by a new tick");

  // a grant only appears while slots are being checked
  a_grant_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(found) |-> $past(ctl.check))
    else $error("grant raised outside a check cycle");

endmodule

// ===== src/stride_tick_scheduler.sv =====
// channel | dir | handshake       | payload
// req     | in  | valid / ready   | req_type, slot, arrival_time, service_time, stride_value
// res     | out | valid / ready   | run_valid, run_slot, tick_time, all_done
// cfg     | in  | cfg_we          | cfg_wdata (process_count)
//
// a load transfer is written to the slot table in the cycle it is taken; ready stays up
// a tick issues one table read per active slot through the single compare unit, then
// passes through a drain, a write-back and a result state
// with no active slot the scan and drain are skipped
// rst (synchronous) clears the sequencer, time, result valid and sets process_count to 1
// a stalled result holds the sequencer in its result state; the table needs no clearing
module stride_tick_scheduler #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sts_pkg::PCNT_W-1:0]   cfg_wdata,
  sts_req_if.sink                      req,
  sts_res_if.source                    res
);

  localparam int IDXW = $clog2(MAX_SLOTS);
  localparam int CNTW = $clog2(MAX_SLOTS+1);
  localparam int SW   = (IDXW > sts_pkg::SLOT_W) ? IDXW : sts_pkg::SLOT_W;
  localparam int EW   = $bits(sts_pkg::slot_entry_t);

  sts_pkg::seq_state_t state;

  logic [sts_pkg::PCNT_W-1:0] proc_cnt;
  logic [sts_pkg::TIME_W-1:0] cur_time;
  logic [CNTW-1:0]            slot_cnt;
  logic [CNTW-1:0]            slot_cnt_next;
  logic [IDXW-1:0]            idx;
  logic                       chk;
  logic [IDXW-1:0]            chk_idx;
  logic                       done_flag;

  logic                       take;
  logic                       take_load;
  logic                       take_tick;
  logic                       slot_ok;
  logic [SW-1:0]              slot_w;
  logic [SW-1:0]              best_w;
  logic                       last_issue;
  logic                       res_free;

  logic                       ram_we;
  logic [IDXW-1:0]            ram_waddr;
  sts_pkg::slot_entry_t       ram_wdata;
  sts_pkg::slot_entry_t       ram_rdata;
  sts_pkg::slot_entry_t       load_entry;
  sts_pkg::slot_entry_t       upd_entry;

  sts_pkg::sel_ctl_t          sel_ctl;
  logic                       found;
  logic [IDXW-1:0]            best_idx;
  sts_pkg::slot_entry_t       best_entry;
  logic [CNTW-1:0]            unfin;
  logic                       finishing;
  logic [CNTW-1:0]            remaining;

  // handshakes
  assign req.ready = (state == sts_pkg::ST_IDLE);
  assign take      = req.valid && req.ready;
  assign take_load = take && (req.req_type == sts_pkg::REQ_LOAD);
  assign take_tick = take && (req.req_type == sts_pkg::REQ_TICK);
  assign res_free  = !res.valid || res.ready;

  // slots past the table are dropped
  assign slot_w  = SW'(req.slot);
  assign slot_ok = int'(req.slot) < MAX_SLOTS;

  // participating slots, clamped to the table size
  assign slot_cnt_next = (int'(proc_cnt) > MAX_SLOTS) ? CNTW'(MAX_SLOTS) : CNTW'(proc_cnt);

  assign last_issue = (CNTW'(idx) + CNTW'(1)) == slot_cnt;

  always_comb begin
    load_entry         = '0;
    load_entry.arrival = req.arrival_time;
    load_entry.service = req.service_time;
    load_entry.stride  = req.stride_value;
  end

  // granted slot after its run: one more run, stride added to pass (wraps)
  always_comb begin
    upd_entry      = best_entry;
    upd_entry.run  = best_entry.run + 16'd1;
    upd_entry.pass = best_entry.pass + sts_pkg::PASS_W'(best_entry.stride);
  end

  // the granted slot may finish on this run; it was unfinished during the scan
  assign finishing = found && (upd_entry.run == best_entry.service);
  assign remaining = unfin - CNTW'(finishing);

  // one write port: loads while idle, write-back in the update cycle
  always_comb begin
    if (state == sts_pkg::ST_UPDATE) begin
      ram_we    = found;
      ram_waddr = best_idx;
      ram_wdata = upd_entry;
    end else begin
      ram_we    = take_load && slot_ok;
      ram_waddr = slot_w[IDXW-1:0];
      ram_wdata = load_entry;
    end
  end

  sts_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign sel_ctl.clear = take_tick;
  assign sel_ctl.check = chk;
  assign sel_ctl.now   = cur_time;

  sts_select #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .ctl        (sel_ctl),
    .chk_idx    (chk_idx),
    .entry      (ram_rdata),
    .found      (found),
    .best_idx   (best_idx),
    .best_entry (best_entry),
    .unfin      (unfin)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_cnt <= sts_pkg::PCNT_W'(1);
    end else if (cfg_we) begin
      proc_cnt <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sts_pkg::ST_IDLE;
      idx      <= '0;
      chk      <= 1'b0;
      cur_time <= '0;
    end else begin
      chk <= (state == sts_pkg::ST_SCAN);
      case (state)
        sts_pkg::ST_IDLE: begin
          idx <= '0;
          if (take_tick) begin
            if (slot_cnt_next == '0) begin
              state <= sts_pkg::ST_UPDATE;
            end else begin
              state <= sts_pkg::ST_SCAN;
            end
          end
        end
        sts_pkg::ST_SCAN: begin
          if (last_issue) begin
            state <= sts_pkg::ST_DRAIN;
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        sts_pkg::ST_DRAIN: begin
          state <= sts_pkg::ST_UPDATE;
        end
        sts_pkg::ST_UPDATE: begin
          state <= sts_pkg::ST_RESULT;
        end
        sts_pkg::ST_RESULT: begin
          if (res_free) begin
            state <= sts_pkg::ST_IDLE;
            if (cur_time != sts_pkg::TIME_MAX) begin
              cur_time <= cur_time + sts_pkg::TIME_W'(1);
            end
          end
        end
        default: begin
          state <= sts_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // per-tick working registers
  always_ff @(posedge clk) begin
    chk_idx <= idx;
    if (take_tick) begin
      slot_cnt <= slot_cnt_next;
    end
    if (state == sts_pkg::ST_UPDATE) begin
      done_flag <= (remaining == '0);
    end
  end

  // result register
  assign best_w = SW'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == sts_pkg::ST_RESULT && res_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sts_pkg::ST_RESULT && res_free) begin
      res.run_valid <= found;
      res.run_slot  <= found ? best_w[sts_pkg::SLOT_W-1:0] : '0;
      res.tick_time <= cur_time;
      res.all_done  <= done_flag;
    end
  end

  // write-back and scan never overlap a load
  a_write_when_quiet: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == sts_pkg::ST_IDLE || state == sts_pkg::ST_UPDATE))
    else $error("table written during scan");

  // an empty process set never grants
  a_empty_no_grant: assert property (@(posedge clk) disable iff (rst)
    (state == sts_pkg::ST_RESULT && slot_cnt == '0) |-> !found)
    else $error("grant with no participating slot");

  // scan index stays inside the participating slots
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == sts_pkg::ST_SCAN) |-> (CNTW'(idx) < slot_cnt))
    else $error("scan index past process count");

  // time holds once saturated
  a_time_sat: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(cur_time) == sts_pkg::TIME_MAX) |-> cur_time == sts_pkg::TIME_MAX)
    else $error("time counter wrapped");

  // a transfer on the result side only follows a completed tick
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == sts_pkg::ST_RESULT))
    else $error("result raised outside result state");

endmodule

// ===== verif/tb_stride_tick_scheduler.sv =====
`timescale 1ns / 1ps

module tb_stride_tick_scheduler;

  localparam int          MAX_SLOTS   = 16;
  localparam int          LONG_HOLD   = 300;
  localparam int          SETTLE      = 40;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int          DIR_ROWS    = 20;
  localparam int          PHASES      = 10;
  localparam int          PHASE_ITEMS = 80;

  // what the directed table does on each row
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_TICK
  } row_kind_t;

  // one result transfer as seen on the res channel
  typedef struct packed {
    logic                       run_valid;
    logic [sts_pkg::SLOT_W-1:0] run_slot;
    logic [sts_pkg::TIME_W-1:0] tick_time;
    logic                       all_done;
  } grant_t;

  // one request transfer as driven on the req channel
  typedef struct packed {
    logic                       req_type;
    logic [sts_pkg::SLOT_W-1:0] slot;
    logic [sts_pkg::TIME_W-1:0] arrival;
    logic [sts_pkg::TIME_W-1:0] service;
    logic [sts_pkg::TIME_W-1:0] stride;
  } sched_req_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [sts_pkg::PCNT_W-1:0] count;
    logic [sts_pkg::SLOT_W-1:0] slot;
    logic [sts_pkg::TIME_W-1:0] arrival;
    logic [sts_pkg::TIME_W-1:0] service;
    logic [sts_pkg::TIME_W-1:0] stride;
    logic                       typed;
    grant_t                     want;
  } dir_row_t;

  // directed opening: the empty schedule, extremes on the table entries, a zero-length
  // process, a zero stride, a reload that clears the counters, arrival on the exact tick,
  // and a pass tie that must go to the lower slot
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // nobody takes part: idle and finished at time zero
    '{ROW_CFG,  5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b1, '{1'b0, 4'd0, 16'd0, 1'b1}},
    // slot 0 with zero stride, slot 15 at the top of every field, slot 1 with no service
    '{ROW_LOAD, 5'd0, 4'd0,  16'd0,     16'd2,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_LOAD, 5'd0, 4'd15, 16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_LOAD, 5'd0, 4'd1,  16'd0,     16'd0,     16'd5,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_CFG,  5'd2, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    // slot 0 runs twice, slot 1 never: then everything is done and the tick is idle
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b1, '{1'b1, 4'd0, 16'd1, 1'b0}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b1, '{1'b1, 4'd0, 16'd2, 1'b1}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b1, '{1'b0, 4'd0, 16'd3, 1'b1}},
    // slot 2 arrives at time 5, slot 0 reloaded so its run count and pass start again
    '{ROW_LOAD, 5'd0, 4'd2,  16'd5,     16'd3,     16'd7,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_LOAD, 5'd0, 4'd0,  16'd0,     16'd3,     16'd7,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_CFG,  5'd3, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    // alternation with equal pass values, then the idle tail
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}},
    '{ROW_TICK, 5'd0, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, '{1'b0, 4'd0, 16'd0, 1'b0}}
  };

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [sts_pkg::PCNT_W-1:0] cfg_wdata;

  sts_req_if req_bus ();
  sts_res_if res_bus ();

  stride_tick_scheduler #(
    .MAX_SLOTS (MAX_SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_bus),
    .res       (res_bus)
  );

  always #5 clk = ~clk;

  // scheduler state as the testbench believes it to be
  logic [sts_pkg::TIME_W-1:0] slot_arrival [MAX_SLOTS];
  logic [sts_pkg::TIME_W-1:0] slot_service [MAX_SLOTS];
  logic [sts_pkg::TIME_W-1:0] slot_stride  [MAX_SLOTS];
  logic [sts_pkg::TIME_W-1:0] slot_runs    [MAX_SLOTS];
  logic [sts_pkg::PASS_W-1:0] slot_pass    [MAX_SLOTS];
  logic [sts_pkg::TIME_W-1:0] sched_now;
  logic [sts_pkg::PCNT_W-1:0] sched_count;

  grant_t      pending_grants [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          steady;
  bit          hold_res_req;

  // load transfer: table entry written, counters cleared
  function automatic void store_slot(input sched_req_t r);
    if (r.slot < MAX_SLOTS) begin
      slot_arrival[r.slot] = r.arrival;
      slot_service[r.slot] = r.service;
      slot_stride[r.slot]  = r.stride;
      slot_runs[r.slot]    = '0;
      slot_pass[r.slot]    = '0;
    end
  endfunction

  // tick transfer: pick the arrived, unfinished slot of least pass (lowest slot on a tie),
  // charge it one stride and one run, then advance the saturating clock
  function automatic grant_t schedule_tick();
    int unsigned                active;
    bit                         found;
    int unsigned                pick;
    logic [sts_pkg::PASS_W-1:0] pick_pass;
    grant_t                     g;
    active    = (sched_count > MAX_SLOTS) ? MAX_SLOTS : sched_count;
    found     = 1'b0;
    pick      = 0;
    pick_pass = '0;
    for (int i = 0; i < active; i++) begin
      if (slot_arrival[i] <= sched_now && slot_runs[i] < slot_service[i] &&
          (!found || slot_pass[i] < pick_pass)) begin
        found     = 1'b1;
        pick      = i;
        pick_pass = slot_pass[i];
      end
    end
    if (found) begin
      slot_pass[pick] = slot_pass[pick] + sts_pkg::PASS_W'(slot_stride[pick]);
      slot_runs[pick] = slot_runs[pick] + 1'b1;
    end
    g.run_valid = found;
    g.run_slot  = found ? sts_pkg::SLOT_W'(pick) : '0;
    g.tick_time = sched_now;
    g.all_done  = 1'b1;
    for (int i = 0; i < active; i++) begin
      if (slot_runs[i] < slot_service[i]) g.all_done = 1'b0;
    end
    if (sched_now != sts_pkg::TIME_MAX) sched_now = sched_now + 1'b1;
    return g;
  endfunction

  // random load, mostly aimed at the taking-part slots with arrivals close to now
  function automatic sched_req_t random_load();
    sched_req_t  r;
    int unsigned act;
    act        = (sched_count == 0) ? 1 : ((sched_count > MAX_SLOTS) ? MAX_SLOTS : sched_count);
    r.req_type = sts_pkg::REQ_LOAD;
    r.slot     = ($urandom_range(0, 3) == 0) ? sts_pkg::SLOT_W'($urandom_range(0, MAX_SLOTS - 1))
                                             : sts_pkg::SLOT_W'($urandom_range(0, act - 1));
    case ($urandom_range(0, 9))
      0:       r.arrival = sts_pkg::TIME_W'($urandom);
      1:       r.arrival = '0;
      default: r.arrival = sched_now + sts_pkg::TIME_W'($urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 9))
      0:       r.service = sts_pkg::TIME_W'($urandom);
      1:       r.service = '0;
      default: r.service = sts_pkg::TIME_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0:       r.stride = sts_pkg::TIME_W'($urandom);
      1:       r.stride = '0;
      default: r.stride = sts_pkg::TIME_W'($urandom_range(1, 16));
    endcase
    return r;
  endfunction

  function automatic sched_req_t random_tick();
    sched_req_t r;
    r          = random_load();
    r.req_type = sts_pkg::REQ_TICK;
    return r;
  endfunction

  task automatic log_mismatch(input string what, input grant_t want, input grant_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want v=%0b s=%0d t=%0d d=%0b got v=%0b s=%0d t=%0d d=%0b",
               $realtime, what, want.run_valid, want.run_slot, want.tick_time, want.all_done,
               got.run_valid, got.run_slot, got.tick_time, got.all_done);
  endtask

  // offer one request after a random gap (none while steady); the predictor moves on once the transfer is taken
  task automatic send_req(input sched_req_t r, input bit typed, input grant_t want);
    int unsigned gap;
    grant_t      g;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= r.req_type;
    req_bus.slot         <= r.slot;
    req_bus.arrival_time <= r.arrival;
    req_bus.service_time <= r.service;
    req_bus.stride_value <= r.stride;
    @(posedge clk iff req_bus.ready);
    if (r.req_type == sts_pkg::REQ_TICK) begin
      g = schedule_tick();
      pending_grants.push_back(typed ? want : g);
    end else begin
      store_slot(r);
    end
    @(negedge clk);
  endtask

  // drop valid and let every tick in flight come back
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // process_count is only touched with the scheduler idle
  task automatic set_process_count(input logic [sts_pkg::PCNT_W-1:0] value);
    drain();
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    @(negedge clk);
    cfg_we      <= 1'b0;
    sched_count = value;
  endtask

  // result side: random hold-offs, one long one on request, check at the taking edge
  initial begin : res_sink
    int unsigned gap;
    grant_t      got;
    grant_t      want;
    @(negedge clk iff !rst);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (hold_res_req) begin
        gap          = LONG_HOLD;
        hold_res_req = 1'b0;
      end
      if (gap != 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk iff res_bus.valid);
      got = '{res_bus.run_valid, res_bus.run_slot, res_bus.tick_time, res_bus.all_done};
      if (pending_grants.size() == 0) begin
        log_mismatch("result with no tick outstanding", '0, got);
      end else begin
        want = pending_grants.pop_front();
        if (got.run_valid !== want.run_valid || got.run_slot !== want.run_slot ||
            got.tick_time !== want.tick_time || got.all_done !== want.all_done)
          log_mismatch("result mismatch", want, got);
      end
      @(negedge clk);
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    sched_req_t r;
    dir_row_t   row;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    req_bus.valid        = 1'b0;
    req_bus.req_type     = sts_pkg::REQ_LOAD;
    req_bus.slot         = '0;
    req_bus.arrival_time = '0;
    req_bus.service_time = '0;
    req_bus.stride_value = '0;
    res_bus.ready        = 1'b0;
    mismatches           = 0;
    cycle_count          = 0;
    steady               = 1'b0;
    hold_res_req         = 1'b0;
    sched_now            = '0;
    sched_count          = 5'd1;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_arrival[i] = '0;
      slot_service[i] = '0;
      slot_stride[i]  = '0;
      slot_runs[i]    = '0;
      slot_pass[i]    = '0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table; the table itself keeps every tick away from unloaded slots
    for (int k = 0; k < DIR_ROWS; k++) begin
      row = DIRECTED[k];
      case (row.kind)
        ROW_CFG: begin
          set_process_count(row.count);
        end
        default: begin
          r.req_type = (row.kind == ROW_TICK) ? sts_pkg::REQ_TICK : sts_pkg::REQ_LOAD;
          r.slot     = row.slot;
          r.arrival  = row.arrival;
          r.service  = row.service;
          r.stride   = row.stride;
          send_req(r, row.typed, row.want);
        end
      endcase
    end

    // fill the whole table so that any process_count is safe from here on
    for (int s = 0; s < MAX_SLOTS; s++) begin
      r      = random_load();
      r.slot = sts_pkg::SLOT_W'(s);
      send_req(r, 1'b0, '0);
    end

    // random phases: full table, count beyond the table with a long result stall,
    // a single slot, nobody, then counts drawn over the whole register
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_process_count(sts_pkg::PCNT_W'(MAX_SLOTS));
        1:       set_process_count(5'd31);
        2:       set_process_count(5'd1);
        3:       set_process_count(5'd0);
        default: set_process_count(sts_pkg::PCNT_W'($urandom_range(0, 31)));
      endcase
      steady = (p == 2) || (p >= 4 && $urandom_range(0, 3) == 0);
      if (p == 1) hold_res_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 35) send_req(random_load(), 1'b0, '0);
        else                            send_req(random_tick(), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sts_pkg.sv
src/sts_req_if.sv
src/sts_res_if.sv
src/sts_ram.sv
src/sts_select.sv
src/stride_tick_scheduler.sv
verif/tb_stride_tick_scheduler.sv
